### design/sprite_entry_tile_expander_macros.svh
// Assertion macros for the sprite entry tile expander checker.
// Used by the bound port checker; needs a clk and rst in scope.
`ifndef SPRITE_ENTRY_TILE_EXPANDER_MACROS_SVH
`define SPRITE_ENTRY_TILE_EXPANDER_MACROS_SVH

// Property checked outside reset.
`define SETX_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property checked at every edge, reset included.
`define SETX_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### design/setx_pkg.sv
// Shared types and constants of the sprite entry tile expander.
// No dependencies; used by the entry setup, the tile walker and the top level.
package setx_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_FLIP   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE_COLUMN = 1'd1;

  localparam logic [15:0] COL_CODE_STEP = 16'd8;
  localparam logic [15:0] ROW_CODE_STEP = 16'd1;
  localparam logic [10:0] CELL_PIX      = 11'd16;
  localparam logic [10:0] X_ORIGIN      = 11'd256;
  localparam logic [10:0] Y_ORIGIN      = 11'd512;
  localparam logic [10:0] X_FLIP_ORIGIN = 11'd768;

  // Start values of one entry, handed from setup to the walker.
  typedef struct packed {
    logic [15:0]        code;
    logic [3:0]         color;
    logic signed [10:0] sx;
    logic signed [10:0] sy;
    logic               fx;
    logic               fy;
    logic [2:0]         col_last;
    logic [2:0]         row_last;
  } setup_t;

endpackage

### design/setx_entry_if.sv
// Input channel of the tile expander: one decoded sprite list entry per beat.
// Stands alone; no package needed.
interface setx_entry_if;
  logic       valid;
  logic       ready;
  logic       first_entry;
  logic [8:0] y_raw;
  logic [15:0] base_code;
  logic [3:0] color_code;
  logic [1:0] width_log2;
  logic [1:0] height_log2;
  logic       mirror_x;
  logic       mirror_y;
  logic [9:0] x_raw;

  modport source (output valid, first_entry, y_raw, base_code, color_code, width_log2,
                  height_log2, mirror_x, mirror_y, x_raw, input ready);
  modport sink   (input valid, first_entry, y_raw, base_code, color_code, width_log2,
                  height_log2, mirror_x, mirror_y, x_raw, output ready);
endinterface

### design/setx_tile_if.sv
// Output channel of the tile expander: one tile draw command per beat.
// Stands alone; no package needed.
interface setx_tile_if;
  logic              valid;
  logic              ready;
  logic [15:0]       tile_code;
  logic [3:0]        tile_color;
  logic signed [10:0] pos_x;
  logic signed [10:0] pos_y;
  logic              draw_flip_x;
  logic              draw_flip_y;
  logic              last_tile;

  modport source (output valid, tile_code, tile_color, pos_x, pos_y, draw_flip_x,
                  draw_flip_y, last_tile, input ready);
  modport sink   (input valid, tile_code, tile_color, pos_x, pos_y, draw_flip_x,
                  draw_flip_y, last_tile, output ready);
endinterface

### design/setx_entry_setup.sv
// Entry setup: sizes, start position, start code and final flips of one entry.
// Depends on setx_pkg.
module setx_entry_setup (
  input  logic                 screen_flip,
  input  logic                 single_column_mode,
  input  logic [8:0]           y_raw,
  input  logic [15:0]          base_code,
  input  logic [3:0]           color_code,
  input  logic [1:0]           width_log2,
  input  logic [1:0]           height_log2,
  input  logic                 mirror_x,
  input  logic                 mirror_y,
  input  logic [9:0]           x_raw,
  output setx_pkg::setup_t     setup
);

  logic [2:0]  w_last;
  logic [2:0]  h_last;
  logic [10:0] w_pix;
  logic [10:0] h_pix;
  logic [10:0] x_ext;
  logic [10:0] y_ext;
  logic        fx;
  logic        fy;

  always_comb begin
    w_last = single_column_mode ? 3'd0 : ~(3'b111 << width_log2);
    h_last = ~(3'b111 << height_log2);
    w_pix  = 11'({w_last, 4'b0000}) + setx_pkg::CELL_PIX;
    h_pix  = 11'({h_last, 4'b0000}) + setx_pkg::CELL_PIX;
    x_ext  = {1'b0, x_raw};
    y_ext  = {2'b00, y_raw};
    fx     = mirror_x ^ screen_flip;
    fy     = mirror_y ^ screen_flip;

    setup.color    = color_code;
    setup.fx       = fx;
    setup.fy       = fy;
    setup.col_last = w_last;
    setup.row_last = h_last;
    // Flipped screen: mirrored y folds back to the raw value.
    setup.sx = $signed(screen_flip ? (setx_pkg::X_FLIP_ORIGIN - w_pix - x_ext)
                                   : (x_ext - setx_pkg::X_ORIGIN));
    setup.sy = $signed(screen_flip ? y_ext : (setx_pkg::Y_ORIGIN - y_ext - h_pix));
    setup.code = base_code
               + (fx ? {10'd0, w_last, 3'b000} : 16'd0)
               + (fy ? {13'd0, h_last} : 16'd0);
  end

endmodule

### design/setx_tile_walker.sv
// Tile walker: steps column-major over the cells of one entry with separate
// code and position adders and holds each command in the output register.
// Depends on setx_pkg and setx_tile_if.
module setx_tile_walker (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  setx_pkg::setup_t  setup,
  output logic              idle,
  setx_tile_if.source       tile_out
);

  typedef enum logic {IDLE, RUN} state_t;

  state_t             state;
  logic [2:0]         col;
  logic [2:0]         row;
  logic [2:0]         col_last;
  logic [2:0]         row_last;
  logic [15:0]        col_code;
  logic [15:0]        code;
  logic signed [10:0] px;
  logic signed [10:0] py;
  logic signed [10:0] sy;
  logic [3:0]         color;
  logic               fx;
  logic               fy;
  logic               slot_free;
  logic               col_done;
  logic               last;
  logic [15:0]        col_code_next;

  assign idle          = (state == IDLE);
  assign slot_free     = !tile_out.valid || tile_out.ready;
  assign col_done      = (row == row_last);
  assign last          = col_done && (col == col_last);
  assign col_code_next = fx ? (col_code - setx_pkg::COL_CODE_STEP)
                            : (col_code + setx_pkg::COL_CODE_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      tile_out.valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          // drop the last command of the previous entry once taken
          if (tile_out.ready) begin
            tile_out.valid <= 1'b0;
          end
          if (load) begin
            state    <= RUN;
            col      <= '0;
            row      <= '0;
            col_last <= setup.col_last;
            row_last <= setup.row_last;
            col_code <= setup.code;
            code     <= setup.code;
            px       <= setup.sx;
            py       <= setup.sy;
            sy       <= setup.sy;
            color    <= setup.color;
            fx       <= setup.fx;
            fy       <= setup.fy;
          end
        end
        RUN: begin
          if (slot_free) begin
            tile_out.valid       <= 1'b1;
            tile_out.tile_code   <= code;
            tile_out.tile_color  <= color;
            tile_out.pos_x       <= px;
            tile_out.pos_y       <= py;
            tile_out.draw_flip_x <= fx;
            tile_out.draw_flip_y <= fy;
            tile_out.last_tile   <= last;
            // advance down the column, or wrap to the top of the next one
            if (col_done) begin
              row      <= '0;
              col      <= col + 3'd1;
              px       <= px + $signed(setx_pkg::CELL_PIX);
              py       <= sy;
              col_code <= col_code_next;
              code     <= col_code_next;
            end else begin
              row  <= row + 3'd1;
              py   <= py + $signed(setx_pkg::CELL_PIX);
              code <= fy ? (code - setx_pkg::ROW_CODE_STEP)
                         : (code + setx_pkg::ROW_CODE_STEP);
            end
            if (last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### design/sprite_entry_tile_expander.sv
// Sprite list entry tile expander, top level.
// Depends on setx_pkg, setx_entry_if, setx_tile_if, setx_entry_setup, setx_tile_walker.
//
// entry_in takes one decoded sprite list entry per beat (valid/ready). tile_out
// gives the tile draw commands of that entry, column-major, one per beat,
// last_tile set on the final one. cfg_wr_en/cfg_index/cfg_data write the
// screen flip and single column registers; write them only while idle.
// An entry of w by h cells, 1 to 64 in all, is first loaded into the walker;
// the tile walker then gives one command per cycle while tile_out does not stall.
// The walker loads the entry in IDLE and puts the first command into the output
// register in RUN. Skipped entries are accepted and give nothing. entry_in.ready
// is low while the walker runs; the next entry is taken while the last command
// still waits in the output register. When tile_out stalls, the walker holds its
// command and count. Reset clears both registers, the skip count and the output valid.
module sprite_entry_tile_expander (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [setx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [setx_pkg::CFG_DATA_W-1:0]  cfg_data,
  setx_entry_if.sink                       entry_in,
  setx_tile_if.source                      tile_out
);

  logic             screen_flip;
  logic             single_column_mode;
  logic [2:0]       entries_to_skip;
  logic             accept;
  logic             process;
  logic             walker_idle;
  setx_pkg::setup_t setup;

  assign entry_in.ready = walker_idle;
  assign accept  = entry_in.valid && entry_in.ready;
  assign process = entry_in.first_entry || single_column_mode || (entries_to_skip == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_flip        <= 1'b0;
      single_column_mode <= 1'b0;
      entries_to_skip    <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          setx_pkg::CFG_SCREEN_FLIP:   screen_flip        <= cfg_data[0];
          setx_pkg::CFG_SINGLE_COLUMN: single_column_mode <= cfg_data[0];
          default: ;
        endcase
      end
      // a wide entry hides the next col_last entries
      if (accept) begin
        entries_to_skip <= process ? setup.col_last : (entries_to_skip - 3'd1);
      end
    end
  end

  setx_entry_setup u_setup (
    .screen_flip        (screen_flip),
    .single_column_mode (single_column_mode),
    .y_raw              (entry_in.y_raw),
    .base_code          (entry_in.base_code),
    .color_code         (entry_in.color_code),
    .width_log2         (entry_in.width_log2),
    .height_log2        (entry_in.height_log2),
    .mirror_x           (entry_in.mirror_x),
    .mirror_y           (entry_in.mirror_y),
    .x_raw              (entry_in.x_raw),
    .setup              (setup)
  );

  setx_tile_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && process),
    .setup    (setup),
    .idle     (walker_idle),
    .tile_out (tile_out)
  );

endmodule

### design/setx_checker.sv
// Port checker for the sprite entry tile expander, bound to the top level.
// Depends on sprite_entry_tile_expander_macros.svh.
`include "sprite_entry_tile_expander_macros.svh"

module setx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tile_code,
  input logic [3:0]  tile_color,
  input logic        draw_flip_x,
  input logic        draw_flip_y,
  input logic        last_tile
);

  `SETX_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid, "output valid after reset")

  `SETX_ASSERT(a_stall_hold, out_valid && !out_ready, ##1 (out_valid && $stable(tile_code)),
               "stalled tile command changed")

  `SETX_ASSERT(a_busy_midentry, out_valid && !last_tile, !in_ready,
               "entry taken while an entry is still expanding")

  `SETX_ASSERT(a_entry_steady, out_valid && out_ready && !last_tile,
               ##1 (out_valid && $stable(tile_color) && $stable(draw_flip_x)
                    && $stable(draw_flip_y)),
               "tile commands of one entry disagree or have a gap")

  // an entry beat only lands between entries
  `SETX_ASSERT(a_ready_idle, in_valid && in_ready, !(out_valid && !last_tile),
               "entry accepted during expansion")

endmodule

bind sprite_entry_tile_expander setx_checker u_setx_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (entry_in.valid),
  .in_ready    (entry_in.ready),
  .out_valid   (tile_out.valid),
  .out_ready   (tile_out.ready),
  .tile_code   (tile_out.tile_code),
  .tile_color  (tile_out.tile_color),
  .draw_flip_x (tile_out.draw_flip_x),
  .draw_flip_y (tile_out.draw_flip_y),
  .last_tile   (tile_out.last_tile)
);
